// ----- hdl/opm_pkg.sv -----
// Package for the optics polynomial map evaluator.
// Constants, sizes and register index codes; no dependencies.
package opm_pkg;
  localparam int MaxTerms  = 64;
  localparam int NumPolys  = 3;
  localparam int FracBits  = 16;
  localparam int MaxDegree = 7;
  localparam int Depth     = NumPolys * MaxTerms;
  localparam int AddrW     = $clog2(Depth);
  localparam int SlotW     = $clog2(MaxTerms);
  localparam int CountW    = SlotW + 1;
  localparam int ExpW      = 12;
  localparam int QW        = 48;

  localparam logic [1:0] RegDeltaCount = 2'd0;
  localparam logic [1:0] RegACount     = 2'd1;
  localparam logic [1:0] RegBCount     = 2'd2;

  localparam logic OpLoad = 1'b0;
  localparam logic OpEval = 1'b1;

  localparam logic signed [QW-1:0] QMax = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] QMin = {1'b1, {(QW-1){1'b0}}};
endpackage

// ----- hdl/optics_polynomial_map_eval.sv -----
// Top level of the optics polynomial map evaluator.
// Uses opm_pkg; term store, sequencer and one shared 32x32 multiplier.
//
// channel | valid/ready       | payload
// in      | in_valid/in_ready | op, target_poly, term_index, exponent_code, coefficient,
//         |                   | pos_x, pos_y, angle_a, angle_b
// cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
// out     | out_valid/out_ready | delta_out, a_out, b_out, saturated
//
// Load: accepted while idle, the next request can follow at once.
// Evaluate: each scanned slot is fetched and its valid bit checked; a valid slot then takes
// a select, a low and a high partial product and a combine step for each factor, one per
// exponent unit (e up to 28) and one for the coefficient, then an add step. One step closes
// each poly and one builds the result; every factor goes through the single multiplier.
// Reset clears valid bits, counts and control. The output register holds a result until
// taken; input waits while busy or while a result is held.
module optics_polynomial_map_eval (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [1:0]         target_poly,
  input  logic [5:0]         term_index,
  input  logic [15:0]        exponent_code,
  input  logic signed [31:0] coefficient,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] angle_a,
  input  logic signed [31:0] angle_b,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] delta_out,
  output logic signed [47:0] a_out,
  output logic signed [47:0] b_out,
  output logic               saturated
);
  localparam int AW = opm_pkg::AddrW;
  localparam int SW = opm_pkg::SlotW;
  localparam int CW = opm_pkg::CountW;
  localparam int QW = opm_pkg::QW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SEL  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_NEXT = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic [2:0] SelCoef = 3'd4;

  logic [2:0] state;
  logic [opm_pkg::ExpW-1:0] exp_mem [opm_pkg::Depth];
  logic [31:0]              coef_mem [opm_pkg::Depth];
  logic [opm_pkg::Depth-1:0] valid_bits;
  logic [CW-1:0] counts [opm_pkg::NumPolys];
  logic signed [31:0] vars [4];
  logic [1:0]  poly;
  logic [CW-1:0] slot;
  logic [AW-1:0] rd_addr;
  logic [opm_pkg::ExpW-1:0] rd_exp;
  logic [31:0] rd_coef;
  logic        rd_valid;
  logic [2:0]  remain [4];
  logic [2:0]  var_sel;   // 0..3 variables, SelCoef coefficient
  logic signed [QW-1:0] elem;
  logic signed [QW-1:0] sum;
  logic signed [QW-1:0] sums [opm_pkg::NumPolys];
  logic        sat;
  logic signed [31:0] mul_b;
  logic signed [QW-1:0] mul_res;
  logic        mul_sat;
  logic [1:0]  mul_step;
  logic [CW-1:0] scan_n;
  logic        load_ok;
  logic [opm_pkg::ExpW-1:0] packed_exp;
  logic [AW-1:0] wr_addr;

  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign cfg_ready = (state == S_IDLE);

  // Decode load exponent code
  always_comb begin
    load_ok = (exponent_code != 16'd0);
    for (int j = 0; j < 4; j++) begin
      if (exponent_code[j*4 +: 4] > 4'(opm_pkg::MaxDegree)) load_ok = 1'b0;
      packed_exp[j*3 +: 3] = exponent_code[j*4 +: 3];
    end
    wr_addr = AW'(target_poly) * AW'(opm_pkg::MaxTerms) + AW'(term_index);
  end

  assign scan_n = (counts[poly] > CW'(opm_pkg::MaxTerms)) ? CW'(opm_pkg::MaxTerms)
                                                          : counts[poly];
  assign rd_addr = AW'(poly) * AW'(opm_pkg::MaxTerms) + AW'(slot[SW-1:0]);

  // Shared multiplier: low then high half of the magnitude, shift, clip
  logic [47:0] ma;
  logic [31:0] mb;
  logic        mneg;
  logic [31:0] mul_a;
  logic [63:0] part;
  logic [63:0] part_lo;
  logic [47:0] part_hi;
  logic [79:0] prod;
  logic [79:0] q;
  logic [47:0] lim;
  always_comb begin
    mneg  = elem[QW-1] ^ mul_b[31];
    ma    = elem[QW-1] ? 48'(-elem) : 48'(elem);
    mb    = mul_b[31] ? 32'(-mul_b) : 32'(mul_b);
    mul_a = (mul_step == 2'd0) ? ma[31:0] : {16'd0, ma[47:32]};
    part  = 64'(mul_a) * 64'(mb);
  end
  always_ff @(posedge clk) begin
    if (state == S_MUL && mul_step == 2'd0) part_lo <= part;
    if (state == S_MUL && mul_step == 2'd1) part_hi <= part[47:0];
  end
  always_comb begin
    prod = 80'(part_lo) + {part_hi, 32'd0};
    q    = prod >> opm_pkg::FracBits;
    lim  = mneg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    mul_sat = (q[79:48] != '0) || (q[47:0] > lim);
    if (mul_sat) mul_res = mneg ? opm_pkg::QMin : opm_pkg::QMax;
    else         mul_res = mneg ? -$signed(q[47:0]) : $signed(q[47:0]);
  end

  always_comb begin
    case (var_sel)
      3'd0: mul_b = vars[0];
      3'd1: mul_b = vars[1];
      3'd2: mul_b = vars[2];
      3'd3: mul_b = vars[3];
      default: mul_b = $signed(rd_coef);
    endcase
  end

  // Saturating add
  logic signed [QW:0] add_w;
  logic signed [QW-1:0] add_res;
  logic add_sat;
  always_comb begin
    add_w = {sum[QW-1], sum} + {elem[QW-1], elem};
    add_sat = add_w[QW] != add_w[QW-1];
    add_res = add_sat ? (add_w[QW] ? opm_pkg::QMin : opm_pkg::QMax) : add_w[QW-1:0];
  end

  // Term memory
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && in_ready && op == opm_pkg::OpLoad && load_ok
        && target_poly < 2'(opm_pkg::NumPolys)) begin
      exp_mem[wr_addr]  <= packed_exp;
      coef_mem[wr_addr] <= coefficient;
    end
    rd_exp  <= exp_mem[rd_addr];
    rd_coef <= coef_mem[rd_addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid_bits <= '0;
      for (int p = 0; p < opm_pkg::NumPolys; p++) counts[p] <= '0;
      out_valid  <= 1'b0;
      mul_step   <= 2'd0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              opm_pkg::RegDeltaCount: counts[0] <= cfg_data;
              opm_pkg::RegACount:     counts[1] <= cfg_data;
              opm_pkg::RegBCount:     counts[2] <= cfg_data;
              default: ;
            endcase
          end
          if (in_valid && in_ready) begin
            if (op == opm_pkg::OpLoad) begin
              if (target_poly < 2'(opm_pkg::NumPolys)) valid_bits[wr_addr] <= load_ok;
            end else begin
              vars[0] <= pos_x; vars[1] <= pos_y;
              vars[2] <= angle_a; vars[3] <= angle_b;
              poly <= 2'd0; slot <= '0; sum <= '0; sat <= 1'b0;
              state <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          if (slot >= scan_n) begin
            sums[poly] <= sum;
            sum <= '0; slot <= '0;
            if (poly == 2'(opm_pkg::NumPolys - 1)) state <= S_DONE;
            else poly <= poly + 2'd1;
          end else begin
            rd_valid <= valid_bits[rd_addr];
            state <= S_READ;
          end
        end
        S_READ: begin
          if (!rd_valid) begin
            slot <= slot + CW'(1);
            state <= S_NEXT;
          end else begin
            for (int j = 0; j < 4; j++) remain[j] <= rd_exp[j*3 +: 3];
            elem <= QW'(1) <<< opm_pkg::FracBits;
            state <= S_SEL;
          end
        end
        S_SEL: begin
          // pick next factor: first variable with power left, else coefficient
          if (remain[0] != 0)      begin var_sel <= 3'd0; remain[0] <= remain[0] - 3'd1; end
          else if (remain[1] != 0) begin var_sel <= 3'd1; remain[1] <= remain[1] - 3'd1; end
          else if (remain[2] != 0) begin var_sel <= 3'd2; remain[2] <= remain[2] - 3'd1; end
          else if (remain[3] != 0) begin var_sel <= 3'd3; remain[3] <= remain[3] - 3'd1; end
          else var_sel <= SelCoef;
          mul_step <= 2'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          // low partial product, high partial product, then take the result
          if (mul_step != 2'd2) mul_step <= mul_step + 2'd1;
          else begin
            elem <= mul_res;
            sat  <= sat | mul_sat;
            state <= (var_sel == SelCoef) ? S_ACC : S_SEL;
          end
        end
        S_ACC: begin
          sum  <= add_res;
          sat  <= sat | add_sat;
          slot <= slot + CW'(1);
          state <= S_NEXT;
        end
        S_DONE: begin
          delta_out <= sums[0]; a_out <= sums[1]; b_out <= sums[2];
          saturated <= sat;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_done_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> out_valid) else $error("result lost");
  a_sel_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (var_sel <= SelCoef)) else $error("bad factor select");
endmodule
